// ----- rtl/core/pncs_pkg.sv -----
// Shared types, constants and helper functions for the palette nearest color search unit.
// No dependencies; every other file of the block but the stream interface uses this package.
package pncs_pkg;

    // Default configuration
    localparam int PALETTE_ENTRIES = 256;
    localparam int CHANNEL_BITS    = 8;

    // Fixed field widths of the item channels
    localparam int IDX_FIELD_W  = 8;
    localparam int CH_FIELD_W   = 8;
    localparam int DIST_FIELD_W = 18;

    // Reset palette layout: 6x6x6 cube, then white with an alpha ramp
    localparam int CUBE_SIDE = 6;
    localparam int CUBE_TOP  = 5;
    localparam int RAMP_DIV  = 39;
    localparam int RAMP_BIAS = 19;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        op_t                    operation;
        logic [IDX_FIELD_W-1:0] entry_index;
        logic [CH_FIELD_W-1:0]  red;
        logic [CH_FIELD_W-1:0]  green;
        logic [CH_FIELD_W-1:0]  blue;
        logic [CH_FIELD_W-1:0]  alpha;
    } req_item_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  nearest_index;
        logic [DIST_FIELD_W-1:0] nearest_distance;
    } rsp_item_t;

    // Sideband that travels with each palette read through the distance pipe
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } scan_tag_t;

    // Cube level k of the reset palette, rounded to nearest; elaboration only
    function automatic int cube_level(int k, int cmax);
        return (k * cmax + CUBE_TOP / 2) / CUBE_TOP;
    endfunction

endpackage

// ----- rtl/core/pncs_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transfer.
// Depends on nothing; the payload type is handed in as a type parameter.
interface pncs_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/core/pncs_palette_mem.sv -----
// Palette storage: one synchronous RAM with one write and one registered read port,
// plus the load sweep that fills the reset palette. Depends on pncs_pkg.
module pncs_palette_mem #(
    parameter int PALETTE_ENTRIES = pncs_pkg::PALETTE_ENTRIES,
    parameter int CHANNEL_BITS    = pncs_pkg::CHANNEL_BITS,
    localparam int IDX_W          = $clog2(PALETTE_ENTRIES),
    localparam int ENTRY_W        = 4 * CHANNEL_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    output logic               init_done
);

    localparam int CB       = CHANNEL_BITS;
    localparam int CMAX_INT = (1 << CB) - 1;
    localparam int RAMP_W   = CB + 5;
    localparam int RAMP_Q   = CMAX_INT / pncs_pkg::RAMP_DIV;
    localparam int RAMP_R   = CMAX_INT % pncs_pkg::RAMP_DIV;

    localparam logic [CB-1:0] CMAX = '1;
    localparam logic [CB-1:0] CUBE_LVL [pncs_pkg::CUBE_SIDE] = '{
        CB'(pncs_pkg::cube_level(0, CMAX_INT)),
        CB'(pncs_pkg::cube_level(1, CMAX_INT)),
        CB'(pncs_pkg::cube_level(2, CMAX_INT)),
        CB'(pncs_pkg::cube_level(3, CMAX_INT)),
        CB'(pncs_pkg::cube_level(4, CMAX_INT)),
        CB'(pncs_pkg::cube_level(5, CMAX_INT))
    };

    logic [ENTRY_W-1:0] mem_array [PALETTE_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]  init_idx_reg,   init_idx_next;
    logic              init_done_reg,  init_done_next;
    logic              cube_phase_reg, cube_phase_next;
    logic [2:0]        cr_reg, cr_next;
    logic [2:0]        cg_reg, cg_next;
    logic [2:0]        cb_reg, cb_next;
    logic [RAMP_W-1:0] ramp_q_reg,   ramp_q_next;
    logic [6:0]        ramp_rem_reg, ramp_rem_next;

    logic [6:0]         rem_sum;
    logic [CB-1:0]      ramp_alpha;
    logic [ENTRY_W-1:0] init_data;

    // Saturate the ramp alpha at full scale
    assign ramp_alpha = (ramp_q_reg > RAMP_W'(CMAX)) ? CMAX : ramp_q_reg[CB-1:0];
    assign init_data  = cube_phase_reg
                      ? {CUBE_LVL[cr_reg], CUBE_LVL[cg_reg], CUBE_LVL[cb_reg], CMAX}
                      : {CMAX, CMAX, CMAX, ramp_alpha};
    assign rem_sum    = ramp_rem_reg + 7'(RAMP_R);

    // Advance the load sweep: cube digits first, then the alpha ramp quotient
    always_comb
    begin
        init_idx_next   = init_idx_reg;
        init_done_next  = init_done_reg;
        cube_phase_next = cube_phase_reg;
        cr_next         = cr_reg;
        cg_next         = cg_reg;
        cb_next         = cb_reg;
        ramp_q_next     = ramp_q_reg;
        ramp_rem_next   = ramp_rem_reg;
        if (!init_done_reg)
        begin
            if (init_idx_reg == IDX_W'(PALETTE_ENTRIES - 1))
            begin
                init_done_next = 1'b1;
            end
            else
            begin
                init_idx_next = init_idx_reg + 1'b1;
            end
            if (cube_phase_reg)
            begin
                if (cb_reg == 3'(pncs_pkg::CUBE_TOP))
                begin
                    cb_next = '0;
                    if (cg_reg == 3'(pncs_pkg::CUBE_TOP))
                    begin
                        cg_next = '0;
                        if (cr_reg == 3'(pncs_pkg::CUBE_TOP))
                        begin
                            cube_phase_next = 1'b0;
                        end
                        else
                        begin
                            cr_next = cr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cg_next = cg_reg + 1'b1;
                    end
                end
                else
                begin
                    cb_next = cb_reg + 1'b1;
                end
            end
            else if (rem_sum >= 7'(pncs_pkg::RAMP_DIV))
            begin
                ramp_rem_next = rem_sum - 7'(pncs_pkg::RAMP_DIV);
                ramp_q_next   = ramp_q_reg + RAMP_W'(RAMP_Q + 1);
            end
            else
            begin
                ramp_rem_next = rem_sum;
                ramp_q_next   = ramp_q_reg + RAMP_W'(RAMP_Q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_idx_reg   <= '0;
            init_done_reg  <= 1'b0;
            cube_phase_reg <= 1'b1;
            cr_reg         <= '0;
            cg_reg         <= '0;
            cb_reg         <= '0;
            ramp_q_reg     <= '0;
            ramp_rem_reg   <= 7'(pncs_pkg::RAMP_BIAS);
        end
        else
        begin
            init_idx_reg   <= init_idx_next;
            init_done_reg  <= init_done_next;
            cube_phase_reg <= cube_phase_next;
            cr_reg         <= cr_next;
            cg_reg         <= cg_next;
            cb_reg         <= cb_next;
            ramp_q_reg     <= ramp_q_next;
            ramp_rem_reg   <= ramp_rem_next;
        end
    end

    // Write port: load sweep after reset, item writes afterwards
    always_ff @(posedge clk)
    begin
        if (!init_done_reg)
        begin
            mem_array[init_idx_reg] <= init_data;
        end
        else if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = init_done_reg;

endmodule

// ----- rtl/core/pncs_dist_pipe.sv -----
// Distance pipe: squares the four channel differences of each palette read,
// sums them and keeps the running best entry. Depends on pncs_pkg.
module pncs_dist_pipe #(
    parameter int PALETTE_ENTRIES = pncs_pkg::PALETTE_ENTRIES,
    parameter int CHANNEL_BITS    = pncs_pkg::CHANNEL_BITS,
    localparam int IDX_W          = $clog2(PALETTE_ENTRIES),
    localparam int ENTRY_W        = 4 * CHANNEL_BITS,
    localparam int DIST_W         = 2 * CHANNEL_BITS + 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pncs_pkg::scan_tag_t tag,
    input  logic [IDX_W-1:0]    idx,
    input  logic [ENTRY_W-1:0]  color,
    input  logic [ENTRY_W-1:0]  rd_data,
    output logic                res_vld,
    output logic [IDX_W-1:0]    best_idx,
    output logic [DIST_W-1:0]   best_dist
);

    localparam int CB = CHANNEL_BITS;
    localparam int SQ_W = 2 * CB;

    pncs_pkg::scan_tag_t tag1_reg, tag2_reg;
    logic [IDX_W-1:0]    idx1_reg, idx2_reg;
    logic [SQ_W-1:0]     sq_reg [4];
    logic [DIST_W-1:0]   sum;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                res_vld_reg;

    // Square one channel difference per lane; register before the sum
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic [CB-1:0] a_ch;
        logic [CB-1:0] b_ch;
        logic [CB-1:0] abs_diff;

        assign a_ch     = color[k*CB +: CB];
        assign b_ch     = rd_data[k*CB +: CB];
        assign abs_diff = (a_ch >= b_ch) ? (a_ch - b_ch) : (b_ch - a_ch);

        always_ff @(posedge clk)
        begin
            sq_reg[k] <= SQ_W'(abs_diff * abs_diff);
        end
    end

    assign sum = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1])
               + DIST_W'(sq_reg[2]) + DIST_W'(sq_reg[3]);

    // Align the read tag with the RAM output and the square stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg    <= '0;
            tag2_reg    <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            tag1_reg    <= tag;
            tag2_reg    <= tag1_reg;
            res_vld_reg <= tag2_reg.vld && tag2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= idx;
        idx2_reg <= idx1_reg;
    end

    // Keep the best: first read seeds it, later reads replace only when strictly closer
    always_ff @(posedge clk)
    begin
        if (tag2_reg.vld && (tag2_reg.first || (sum < best_dist_reg)))
        begin
            best_dist_reg <= sum;
            best_idx_reg  <= idx2_reg;
        end
    end

    assign res_vld   = res_vld_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule

// ----- rtl/core/palette_nearest_color_search_unit.sv -----
// Palette nearest color search unit. A lookup scans every palette entry, one RAM read a cycle;
// the result passes the RAM read port and the distance pipe into the response register, and
// the next item can transfer only once that result is loaded. A write goes straight to the RAM.
// After reset a load sweep fills the reset palette; no item is taken until it ends.
// Depends on pncs_pkg, pncs_stream_if, pncs_palette_mem, pncs_dist_pipe.
module palette_nearest_color_search_unit #(
    parameter int PALETTE_ENTRIES = pncs_pkg::PALETTE_ENTRIES,
    parameter int CHANNEL_BITS    = pncs_pkg::CHANNEL_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    pncs_stream_if.sink   req,
    pncs_stream_if.source rsp
);

    localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
    localparam int CB      = CHANNEL_BITS;
    localparam int ENTRY_W = 4 * CB;
    localparam int DIST_W  = 2 * CB + 2;
    localparam int CMP_W   = ((IDX_W > pncs_pkg::IDX_FIELD_W) ? IDX_W : pncs_pkg::IDX_FIELD_W) + 1;

    pncs_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [ENTRY_W-1:0]  color_reg;
    logic                rsp_vld_reg;
    pncs_pkg::rsp_item_t rsp_item_reg;

    logic                accept;
    logic                is_lookup;
    logic                in_range;
    logic                out_free;
    logic                rsp_load;
    logic [ENTRY_W-1:0]  req_color;
    logic                mem_wr_en;
    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;
    logic [ENTRY_W-1:0]  mem_rd_data;
    logic                init_done;
    pncs_pkg::scan_tag_t scan_tag;
    logic                res_vld;
    logic [IDX_W-1:0]    best_idx;
    logic [DIST_W-1:0]   best_dist;

    assign accept    = req.valid && req.ready;
    assign is_lookup = (req.payload.operation == pncs_pkg::OP_LOOKUP);
    assign in_range  = CMP_W'(req.payload.entry_index) < CMP_W'(PALETTE_ENTRIES);
    assign out_free  = !rsp_vld_reg || rsp.ready;
    assign req_color = {CB'(req.payload.red), CB'(req.payload.green),
                        CB'(req.payload.blue), CB'(req.payload.alpha)};
    assign mem_wr_en = accept && !is_lookup && in_range;

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            pncs_pkg::ST_INIT:
            begin
                if (init_done)
                begin
                    state_next = pncs_pkg::ST_IDLE;
                end
            end
            pncs_pkg::ST_IDLE:
            begin
                if (accept && is_lookup)
                begin
                    state_next    = pncs_pkg::ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            pncs_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_W'(PALETTE_ENTRIES - 2))
                begin
                    state_next = pncs_pkg::ST_DRAIN;
                end
            end
            pncs_pkg::ST_DRAIN:
            begin
                if (res_vld)
                begin
                    state_next = out_free ? pncs_pkg::ST_IDLE : pncs_pkg::ST_HOLD;
                end
            end
            pncs_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = pncs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pncs_pkg::ST_INIT;
            end
        endcase
    end

    // Outputs: read issue, scan tag, request ready and result load
    always_comb
    begin
        req.ready   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = scan_cnt_reg;
        scan_tag    = '0;
        rsp_load    = 1'b0;
        case (state_reg)
            pncs_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                // Last entry goes first
                if (accept && is_lookup)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = IDX_W'(PALETTE_ENTRIES - 1);
                    scan_tag.vld   = 1'b1;
                    scan_tag.first = 1'b1;
                end
            end
            pncs_pkg::ST_SCAN:
            begin
                mem_rd_en     = 1'b1;
                scan_tag.vld  = 1'b1;
                scan_tag.last = (scan_cnt_reg == IDX_W'(PALETTE_ENTRIES - 2));
            end
            pncs_pkg::ST_DRAIN:
            begin
                rsp_load = res_vld && out_free;
            end
            pncs_pkg::ST_HOLD:
            begin
                rsp_load = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pncs_pkg::ST_INIT;
            scan_cnt_reg <= '0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            if (rsp_load)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // Hold the lookup color and the pending result
    always_ff @(posedge clk)
    begin
        if (accept && is_lookup)
        begin
            color_reg <= req_color;
        end
        if (rsp_load)
        begin
            rsp_item_reg.nearest_index    <= pncs_pkg::IDX_FIELD_W'(best_idx);
            rsp_item_reg.nearest_distance <= pncs_pkg::DIST_FIELD_W'(best_dist);
        end
    end

    assign rsp.valid   = rsp_vld_reg;
    assign rsp.payload = rsp_item_reg;

    pncs_palette_mem #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .CHANNEL_BITS    (CHANNEL_BITS)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (mem_wr_en),
        .wr_addr   (IDX_W'(req.payload.entry_index)),
        .wr_data   (req_color),
        .rd_en     (mem_rd_en),
        .rd_addr   (mem_rd_addr),
        .rd_data   (mem_rd_data),
        .init_done (init_done)
    );

    pncs_dist_pipe #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .CHANNEL_BITS    (CHANNEL_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (scan_tag),
        .idx       (mem_rd_addr),
        .color     (color_reg),
        .rd_data   (mem_rd_data),
        .res_vld   (res_vld),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

`ifndef ASSERT_OFF
    a_res_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld |-> (state_reg == pncs_pkg::ST_DRAIN))
        else $error("scan result arrived outside drain");

    a_wr_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == pncs_pkg::ST_IDLE) && init_done)
        else $error("palette write outside idle");

    a_rd_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> init_done)
        else $error("palette read during load sweep");

    a_lookup_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_lookup) |=> (state_reg == pncs_pkg::ST_SCAN))
        else $error("lookup transfer did not start a scan");
`endif

endmodule

// ----- tb/palette_nearest_color_search_unit_tb.sv -----
// Self-checking testbench for palette_nearest_color_search_unit: directed table, then random items.
// Depends on pncs_pkg, pncs_stream_if and the RTL of the unit; keeps its own copy of the palette.
module palette_nearest_color_search_unit_tb;

    localparam int NUM_RANDOM     = 680;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = pncs_pkg::PALETTE_ENTRIES + 40;
    localparam int HOLDOFF_AT     = 40;
    localparam int HOLDOFF_CYCLES = 2000;
    localparam int NUM_DIRECTED   = 23;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_t;

    // One row of the directed table; want_* is used only when pinned is set
    typedef struct packed {
        pncs_pkg::op_t op;
        logic [7:0]    entry;
        color_t        color;
        logic          pinned;
        logic [7:0]    want_index;
        logic [17:0]   want_distance;
    } stim_row_t;

    stim_row_t dir_rows [NUM_DIRECTED] = '{
        // reset palette: white opaque hits the last entry, black and the ramp start
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'hFFFFFFFF, 1'b1, 8'd255, 18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h000000FF, 1'b1, 8'd0,   18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h00000000, 1'b1, 8'd0,   18'd65025},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'hFFFFFF00, 1'b1, 8'd216, 18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h00FF00FF, 1'b1, 8'd30,  18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h80808080, 1'b0, 8'd0,   18'd0},
        // exact match on the last entry, and a near miss of it, both pick the last entry
        '{pncs_pkg::OP_WRITE,  8'd255, 32'h00000000, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h00000000, 1'b1, 8'd255, 18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h01000000, 1'b1, 8'd255, 18'd1},
        // tie between two scanned entries goes to the lower index
        '{pncs_pkg::OP_WRITE,  8'd100, 32'h0A141E28, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_WRITE,  8'd50,  32'h0A141E28, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h0A141E29, 1'b1, 8'd50,  18'd1},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h0A141E28, 1'b1, 8'd50,  18'd0},
        // tie between the last entry and a scanned one goes to the last entry
        '{pncs_pkg::OP_WRITE,  8'd255, 32'hC8C8C8C8, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_WRITE,  8'd3,   32'hCAC8C8C8, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'hC9C8C8C8, 1'b1, 8'd255, 18'd1},
        // duplicate of the cube white at entry 0 wins over entry 215
        '{pncs_pkg::OP_WRITE,  8'd0,   32'hFFFFFFFF, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'hFFFFFFFF, 1'b1, 8'd0,   18'd0},
        '{pncs_pkg::OP_WRITE,  8'd255, 32'hFFFFFFFF, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'hFFFFFFFF, 1'b1, 8'd255, 18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h5AA53CC3, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_WRITE,  8'd128, 32'h55AA55AA, 1'b0, 8'd0,   18'd0},
        '{pncs_pkg::OP_LOOKUP, 8'd0,   32'h55AA55AA, 1'b0, 8'd0,   18'd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pncs_stream_if #(.payload_t(pncs_pkg::req_item_t)) req_if ();
    pncs_stream_if #(.payload_t(pncs_pkg::rsp_item_t)) rsp_if ();

    palette_nearest_color_search_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    color_t              palette_copy [pncs_pkg::PALETTE_ENTRIES];
    pncs_pkg::rsp_item_t pending_nearest [$];
    int                  fail_count    = 0;
    int                  cycle_count   = 0;
    int                  results_seen  = 0;
    int                  burst_left    = 0;
    bit                  holdoff_done  = 1'b0;

    // Clock: period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hold reset at start, then release it
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("palette_nearest_color_search_unit_tb NOT OK");
            $finish;
        end
    end

    // Fill the palette copy with the cube and the white alpha ramp
    function automatic void load_reset_palette();
        int a;
        for (int i = 0; i < pncs_pkg::PALETTE_ENTRIES; i++)
        begin
            if (i < 216)
            begin
                palette_copy[i].red   = 8'(((i / 36) * 255 + 2) / 5);
                palette_copy[i].green = 8'((((i / 6) % 6) * 255 + 2) / 5);
                palette_copy[i].blue  = 8'(((i % 6) * 255 + 2) / 5);
                palette_copy[i].alpha = 8'hFF;
            end
            else
            begin
                a = ((i - 216) * 255 + 19) / 39;
                if (a > 255)
                    a = 255;
                palette_copy[i] = {8'hFF, 8'hFF, 8'hFF, 8'(a)};
            end
        end
    endfunction

    function automatic int color_distance(color_t x, color_t y);
        int sum;
        int d;
        sum = 0;
        for (int k = 0; k < 4; k++)
        begin
            d = int'(x[8*k +: 8]) - int'(y[8*k +: 8]);
            sum += d * d;
        end
        return sum;
    endfunction

    // Last entry first with early exit on exact match, then strictly closer entries win
    function automatic pncs_pkg::rsp_item_t search_nearest(color_t probe);
        pncs_pkg::rsp_item_t res;
        int                  best;
        int                  best_idx;
        int                  d;
        best_idx = pncs_pkg::PALETTE_ENTRIES - 1;
        best     = color_distance(probe, palette_copy[best_idx]);
        if (best != 0)
        begin
            for (int i = 0; i < pncs_pkg::PALETTE_ENTRIES - 1; i++)
            begin
                d = color_distance(probe, palette_copy[i]);
                if (d < best)
                begin
                    best     = d;
                    best_idx = i;
                end
            end
        end
        res.nearest_index    = 8'(best_idx);
        res.nearest_distance = 18'(best);
        return res;
    endfunction

    // Apply an accepted item to the palette copy or queue its expected result
    function automatic void record_transfer(pncs_pkg::req_item_t it, bit pinned,
                                            pncs_pkg::rsp_item_t want);
        color_t c;
        c = {it.red, it.green, it.blue, it.alpha};
        if (it.operation == pncs_pkg::OP_WRITE)
            palette_copy[it.entry_index] = c;
        else if (pinned)
            pending_nearest.push_back(want);
        else
            pending_nearest.push_back(search_nearest(c));
    endfunction

    // Mix of writes and lookups; many colors copy or nudge stored entries to force ties
    function automatic pncs_pkg::req_item_t random_item();
        pncs_pkg::req_item_t it;
        color_t              base;
        color_t              c;
        int                  pick;
        int                  v;
        it.operation   = ($urandom_range(0, 99) < 35) ? pncs_pkg::OP_WRITE : pncs_pkg::OP_LOOKUP;
        it.entry_index = 8'($urandom);
        if (it.operation == pncs_pkg::OP_WRITE && $urandom_range(0, 5) == 0)
            it.entry_index = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        base = palette_copy[($urandom_range(0, 4) == 0)
                            ? pncs_pkg::PALETTE_ENTRIES - 1
                            : $urandom_range(0, pncs_pkg::PALETTE_ENTRIES - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 25)
            c = color_t'($urandom);
        else if (pick < 50)
            c = base;
        else if (pick < 85)
        begin
            for (int k = 0; k < 4; k++)
            begin
                v = int'(base[8*k +: 8]) + int'($urandom_range(0, 6)) - 3;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                c[8*k +: 8] = 8'(v);
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                c[8*k +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        end
        it.red   = c.red;
        it.green = c.green;
        it.blue  = c.blue;
        it.alpha = c.alpha;
        return it;
    endfunction

    // Offer one item in bursts; drop valid only between bursts, return after the transfer
    task automatic offer_item(input pncs_pkg::req_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            req_if.valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= it;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Stimulus: directed table, random items, drain, verdict
    initial
    begin : stimulus
        pncs_pkg::req_item_t it;
        pncs_pkg::rsp_item_t want;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        load_reset_palette();
        @(posedge rst_n);
        @(posedge clk);
        foreach (dir_rows[r])
        begin
            it.operation        = dir_rows[r].op;
            it.entry_index      = dir_rows[r].entry;
            it.red              = dir_rows[r].color.red;
            it.green            = dir_rows[r].color.green;
            it.blue             = dir_rows[r].color.blue;
            it.alpha            = dir_rows[r].color.alpha;
            want.nearest_index    = dir_rows[r].want_index;
            want.nearest_distance = dir_rows[r].want_distance;
            offer_item(it);
            record_transfer(it, dir_rows[r].pinned, want);
        end
        want = '0;
        repeat (NUM_RANDOM)
        begin
            it = random_item();
            offer_item(it);
            record_transfer(it, 1'b0, want);
        end
        req_if.valid <= 1'b0;
        while (pending_nearest.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("palette_nearest_color_search_unit_tb OK");
        else
            $display("palette_nearest_color_search_unit_tb NOT OK");
        $finish;
    end

    // Result side: stall on a rotating pattern, with one long hold-off to back up the block
    initial
    begin : result_sink
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!holdoff_done && results_seen >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else
            begin
                case ((cycle_count / 700) % 4)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_if.ready <= ((cycle_count % 5) < 3);
                    default: rsp_if.ready <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_results
        pncs_pkg::rsp_item_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_seen++;
            if (pending_nearest.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual index %0d distance %0d",
                         $time, rsp_if.payload.nearest_index, rsp_if.payload.nearest_distance);
            end
            else
            begin
                want = pending_nearest.pop_front();
                if (rsp_if.payload.nearest_index !== want.nearest_index)
                begin
                    fail_count++;
                    $display("%0t: nearest_index: expected %0d, actual %0d",
                             $time, want.nearest_index, rsp_if.payload.nearest_index);
                end
                if (rsp_if.payload.nearest_distance !== want.nearest_distance)
                begin
                    fail_count++;
                    $display("%0t: nearest_distance: expected %0d, actual %0d",
                             $time, want.nearest_distance, rsp_if.payload.nearest_distance);
                end
            end
        end
    end

endmodule

// ----- sim.f -----
rtl/core/pncs_pkg.sv
rtl/core/pncs_stream_if.sv
rtl/core/pncs_palette_mem.sv
rtl/core/pncs_dist_pipe.sv
rtl/core/palette_nearest_color_search_unit.sv
tb/palette_nearest_color_search_unit_tb.sv
